// ===== rtl/kmp_pkg.sv =====
// shared constants, types and codes for the streaming kmp matcher
`timescale 1ns / 1ps
`default_nettype none
package kmp_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 32;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int POS_W = POSITION_BITS;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_TEXT    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_DROPPED    = 2'd1;
  localparam logic [1:0] STATUS_NO_PATTERN = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } kmp_in_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_start;
    logic [1:0]  status;
  } kmp_out_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_byte;
    logic [IDX_W-1:0] wr_link;
    logic [IDX_W-1:0] cmp_idx;
    logic [IDX_W-1:0] link_idx;
    logic [7:0]       probe_byte;
  } kmp_cell_ctl_t;

  // partial results passed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] link;
  } kmp_chain_t;

endpackage
`default_nettype wire

// ===== rtl/kmp_cell.sv =====
// one pattern cell: stored byte, failure link and local compare
`timescale 1ns / 1ps
`default_nettype none
module kmp_cell (
  input  logic                      clk,
  input  logic [kmp_pkg::IDX_W-1:0] cell_index,
  input  kmp_pkg::kmp_cell_ctl_t    ctl,
  input  kmp_pkg::kmp_chain_t       chain_in,
  output kmp_pkg::kmp_chain_t       chain_out
);

  logic [7:0]                pat_byte;
  logic [kmp_pkg::IDX_W-1:0] link;

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.wr_idx == cell_index)) begin
      pat_byte <= ctl.wr_byte;
      link     <= ctl.wr_link;
    end
  end

  always_comb begin
    chain_out.hit  = chain_in.hit |
                     ((ctl.cmp_idx == cell_index) && (pat_byte == ctl.probe_byte));
    chain_out.link = chain_in.link |
                     ((ctl.link_idx == cell_index) ? link : '0);
  end

endmodule
`default_nettype wire

// ===== rtl/kmp_stream_matcher_top.sv =====
// top level: sequencer, prefix walker and the row of pattern cells
//
// Streaming Knuth-Morris-Pratt matcher for patterns of up to MAX_PATTERN bytes. Start,
// restart, dropped-byte, no-pattern text and first-byte append items finish straight from
// idle. Other append and text items enter the walk, which follows failure links: every
// walk step is one pass of the prefix length through the row of pattern cells, which
// compares the byte and returns the link in the same cycle. A result is held in an output
// register, so the next item is accepted while a finished result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module kmp_stream_matcher_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  kmp_pkg::kmp_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output kmp_pkg::kmp_out_t result
);

  localparam int IDX_W = kmp_pkg::IDX_W;
  localparam int CNT_W = kmp_pkg::CNT_W;
  localparam int POS_W = kmp_pkg::POS_W;
  localparam int MAXP  = kmp_pkg::MAX_PATTERN;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   build_prefix, build_prefix_next;
  logic [IDX_W-1:0]   match_prefix, match_prefix_next;
  logic [IDX_W-1:0]   last_link, last_link_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [IDX_W-1:0]   walk_prefix, walk_prefix_next;
  logic [7:0]         walk_byte, walk_byte_next;
  logic               walk_text, walk_text_next;
  kmp_pkg::kmp_out_t  res, res_next;
  kmp_pkg::kmp_out_t  result_next;
  logic               result_valid_next;

  kmp_pkg::kmp_cell_ctl_t ctl;
  kmp_pkg::kmp_chain_t    chain [MAXP+1];

  logic             item_fire;
  logic             slot_free;
  logic             finish;
  kmp_pkg::kmp_out_t fin_res;
  logic [CNT_W-1:0] j_fin;
  logic [POS_W-1:0] start_full;
  logic             full;

  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign full       = (count == CNT_W'(MAXP));
  assign start_full = pos - POS_W'(count - CNT_W'(1));
  assign j_fin      = chain[MAXP].hit ? (CNT_W'(walk_prefix) + CNT_W'(1)) : '0;

  genvar gi;
  assign chain[0] = '0;
  generate
    for (gi = 0; gi < MAXP; gi++) begin : g_cell
      kmp_cell u_cell (
        .clk        (clk),
        .cell_index (IDX_W'(gi)),
        .ctl        (ctl),
        .chain_in   (chain[gi]),
        .chain_out  (chain[gi+1])
      );
    end
  endgenerate

  always_comb begin
    state_next        = state;
    count_next        = count;
    build_prefix_next = build_prefix;
    match_prefix_next = match_prefix;
    last_link_next    = last_link;
    pos_next          = pos;
    walk_prefix_next  = walk_prefix;
    walk_byte_next    = walk_byte;
    walk_text_next    = walk_text;
    res_next          = res;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    finish            = 1'b0;
    fin_res           = '0;

    ctl            = '0;
    ctl.cmp_idx    = walk_prefix;
    ctl.link_idx   = walk_prefix - IDX_W'(1);
    ctl.probe_byte = walk_byte;
    ctl.wr_byte    = walk_byte;
    ctl.wr_link    = IDX_W'(j_fin);
    ctl.wr_idx     = IDX_W'(count);

    case (state)
      S_IDLE: begin
        if (item_fire) begin
          case (item.command)
            kmp_pkg::CMD_START: begin
              ctl.wr_en         = 1'b1;
              ctl.wr_idx        = '0;
              ctl.wr_byte       = item.data_byte;
              ctl.wr_link       = '0;
              count_next        = CNT_W'(1);
              build_prefix_next = '0;
              match_prefix_next = '0;
              last_link_next    = '0;
              pos_next          = '0;
              finish            = 1'b1;
            end
            kmp_pkg::CMD_APPEND: begin
              if (full) begin
                fin_res.status = kmp_pkg::STATUS_DROPPED;
                finish         = 1'b1;
              end else if (count == '0) begin
                ctl.wr_en         = 1'b1;
                ctl.wr_idx        = '0;
                ctl.wr_byte       = item.data_byte;
                ctl.wr_link       = '0;
                count_next        = CNT_W'(1);
                build_prefix_next = '0;
                last_link_next    = '0;
                finish            = 1'b1;
              end else begin
                walk_byte_next   = item.data_byte;
                walk_text_next   = 1'b0;
                walk_prefix_next = build_prefix;
                state_next       = S_WALK;
              end
            end
            kmp_pkg::CMD_TEXT: begin
              if (count == '0) begin
                fin_res.status = kmp_pkg::STATUS_NO_PATTERN;
                pos_next       = pos + POS_W'(1);
                finish         = 1'b1;
              end else begin
                walk_byte_next   = item.data_byte;
                walk_text_next   = 1'b1;
                walk_prefix_next = match_prefix;
                state_next       = S_WALK;
              end
            end
            default: begin
              match_prefix_next = '0;
              pos_next          = '0;
              finish            = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        if ((walk_prefix == '0) || chain[MAXP].hit) begin
          finish = 1'b1;
          if (walk_text) begin
            pos_next = pos + POS_W'(1);
            if (j_fin == count) begin
              fin_res.match_found = 1'b1;
              fin_res.match_start = 32'(start_full);
              match_prefix_next   = last_link;
            end else begin
              match_prefix_next = IDX_W'(j_fin);
            end
          end else begin
            ctl.wr_en         = 1'b1;
            build_prefix_next = IDX_W'(j_fin);
            last_link_next    = IDX_W'(j_fin);
            count_next        = count + CNT_W'(1);
          end
        end else begin
          walk_prefix_next = chain[MAXP].link;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          result_next       = res;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      if (slot_free) begin
        result_next       = fin_res;
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end else begin
        res_next   = fin_res;
        state_next = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      build_prefix <= '0;
      match_prefix <= '0;
      last_link    <= '0;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      build_prefix <= build_prefix_next;
      match_prefix <= match_prefix_next;
      last_link    <= last_link_next;
      pos          <= pos_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_prefix <= walk_prefix_next;
    walk_byte   <= walk_byte_next;
    walk_text   <= walk_text_next;
    res         <= res_next;
    result      <= result_next;
  end

`ifndef SYNTH
  a_walk_has_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (count != '0))
    else $error("walk started with empty pattern");

  a_walk_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (CNT_W'(walk_prefix) < count))
    else $error("walk prefix out of pattern");

  a_match_below_count: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (CNT_W'(match_prefix) < count))
    else $error("match prefix not below pattern length");

  a_build_below_count: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (CNT_W'(build_prefix) < count))
    else $error("build prefix not below pattern length");

  a_match_status_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.match_found) |-> (result.status == kmp_pkg::STATUS_OK))
    else $error("match reported with error status");
`endif

endmodule
`default_nettype wire

// ===== tb/kmp_stream_matcher_top_test.sv =====
// testbench for the streaming kmp matcher: directed and random streams against a predictor
`timescale 1ns / 1ps
module kmp_stream_matcher_top_test;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAXP  = kmp_pkg::MAX_PATTERN;
  localparam int IDX_W = kmp_pkg::IDX_W;
  localparam int CNT_W = kmp_pkg::CNT_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  kmp_pkg::kmp_in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  kmp_pkg::kmp_out_t result;

  kmp_stream_matcher_top i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] pat_bytes [MAXP];
  logic [CNT_W-1:0] pat_links [MAXP];
  int unsigned pat_len = 0;
  int unsigned border_len = 0;
  int unsigned text_prefix = 0;
  logic [31:0] text_pos = '0;

  kmp_pkg::kmp_out_t expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  function automatic int unsigned extend_prefix(int unsigned j, logic [7:0] b);
    while (j > 0 && j < MAXP && pat_bytes[IDX_W'(j)] != b)
      j = int'(pat_links[IDX_W'(j - 1)]);
    if (j < MAXP && pat_bytes[IDX_W'(j)] == b) j++;
    return j;
  endfunction

  function automatic kmp_pkg::kmp_out_t predict_match(kmp_pkg::kmp_in_t it);
    kmp_pkg::kmp_out_t r;
    int unsigned j;
    r = '0;
    r.status = kmp_pkg::STATUS_OK;
    case (it.command)
      kmp_pkg::CMD_START: begin
        pat_bytes[0] = it.data_byte;
        pat_links[0] = '0;
        pat_len = 1;
        border_len = 0;
        text_prefix = 0;
        text_pos = '0;
      end
      kmp_pkg::CMD_APPEND: begin
        if (pat_len >= MAXP) begin
          r.status = kmp_pkg::STATUS_DROPPED;
        end else if (pat_len == 0) begin
          pat_bytes[0] = it.data_byte;
          pat_links[0] = '0;
          pat_len = 1;
          border_len = 0;
        end else begin
          j = extend_prefix(border_len, it.data_byte);
          pat_bytes[IDX_W'(pat_len)] = it.data_byte;
          pat_links[IDX_W'(pat_len)] = CNT_W'(j);
          border_len = j;
          pat_len++;
        end
      end
      kmp_pkg::CMD_TEXT: begin
        if (pat_len == 0) begin
          r.status = kmp_pkg::STATUS_NO_PATTERN;
        end else begin
          j = extend_prefix(text_prefix, it.data_byte);
          if (j >= pat_len) begin
            r.match_found = 1'b1;
            r.match_start = text_pos - 32'(pat_len - 1);
            j = int'(pat_links[IDX_W'(pat_len - 1)]);
          end
          text_prefix = j;
        end
        text_pos = text_pos + 32'd1;
      end
      default: begin
        text_prefix = 0;
        text_pos = '0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(kmp_pkg::kmp_out_t got);
    kmp_pkg::kmp_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transfer", 32'(got), '0);
    end else begin
      want = expected_results.pop_front();
      if (got.match_found !== want.match_found)
        report_mismatch("match_found", 32'(got.match_found), 32'(want.match_found));
      if (got.match_start !== want.match_start)
        report_mismatch("match_start", got.match_start, want.match_start);
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
    end
  endtask

  task automatic push_item(logic [1:0] cmd, logic [7:0] data);
    kmp_pkg::kmp_in_t it;
    int unsigned gap;
    it.command = cmd;
    it.data_byte = data;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_results.insert(expected_results.size(), predict_match(it));
    items_sent++;
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_pattern_and_overlap();
    push_item(kmp_pkg::CMD_TEXT, 8'h00);
    push_item(kmp_pkg::CMD_TEXT, 8'hff);
    push_item(kmp_pkg::CMD_RESTART, 8'h5a);
    push_item(kmp_pkg::CMD_APPEND, 8'haa);
    push_item(kmp_pkg::CMD_APPEND, 8'haa);
    repeat (3) push_item(kmp_pkg::CMD_TEXT, 8'haa);
  endtask

  task automatic test_full_store();
    push_item(kmp_pkg::CMD_START, 8'h00);
    for (int i = 1; i < MAXP; i++) push_item(kmp_pkg::CMD_APPEND, (i % 2) ? 8'hff : 8'h00);
    push_item(kmp_pkg::CMD_APPEND, 8'h55);
  endtask

  task automatic test_random_streams();
    logic [7:0] alpha [4];
    int unsigned alpha_n;
    int unsigned plen;
    int unsigned tlen;
    int unsigned r;
    while (items_sent < RANDOM_ITEMS) begin
      send_quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) wait_for_results();
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(5, 15))
          push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        alpha_n = $urandom_range(1, 4);
        foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        if (r < 12) plen = $urandom_range(1, 5);
        else if (r < 17) plen = $urandom_range(6, MAXP);
        else plen = $urandom_range(MAXP + 1, MAXP + 2);
        push_item(kmp_pkg::CMD_START, alpha[2'($urandom_range(0, alpha_n - 1))]);
        repeat (plen - 1)
          push_item(kmp_pkg::CMD_APPEND, alpha[2'($urandom_range(0, alpha_n - 1))]);
        if ($urandom_range(0, 4) == 0)
          push_item(kmp_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
        tlen = $urandom_range(8, 48);
        repeat (tlen) begin
          r = $urandom_range(0, 99);
          if (r < 6)
            push_item(kmp_pkg::CMD_APPEND, alpha[2'($urandom_range(0, alpha_n - 1))]);
          else if (r < 9)
            push_item(kmp_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
          else
            push_item(kmp_pkg::CMD_TEXT, alpha[2'($urandom_range(0, alpha_n - 1))]);
        end
      end
    end
    send_quiet = 1'b0;
  endtask

  // result side: random stalls, checks every transfer
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_pattern_and_overlap();
    test_full_store();
    wait_for_results();
    test_random_streams();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
